// ----- hw/rtl/lfu_pkg.sv -----
package lfu_pkg;

   localparam int MaxEntries = 16;
   localparam int CountBits  = 16;
   localparam int SlotBits   = $clog2(MaxEntries);
   localparam int OccBits    = $clog2(MaxEntries + 1);
   localparam int CapBits    = 5;
   localparam int DataBits   = 32;

   localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_SET = 1'b1;

   localparam logic [0:0] ADDR_CAPACITY = 1'b0;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic choose;
      logic commit;
   } ctrl_type;

endpackage

// ----- hw/rtl/lfu_datapath.sv -----
module lfu_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  lfu_pkg::ctrl_type                  ctrl,
   input  logic [lfu_pkg::CapBits-1:0]        capacity,
   input  logic                               mode,
   input  logic signed [lfu_pkg::DataBits-1:0] lookup_key,
   input  logic signed [lfu_pkg::DataBits-1:0] write_value,
   output logic                               hit,
   output logic signed [lfu_pkg::DataBits-1:0] read_value
);
   import lfu_pkg::*;

   logic [MaxEntries-1:0]    valid_ff;
   logic [DataBits-1:0]      key_ff   [MaxEntries];
   logic [DataBits-1:0]      value_ff [MaxEntries];
   logic [CountBits-1:0]     count_ff [MaxEntries];
   logic [SlotBits-1:0]      rank_ff  [MaxEntries];
   logic [OccBits-1:0]       occ_ff;

   logic                     mode_ff;
   logic [DataBits-1:0]      key_in_ff;
   logic [DataBits-1:0]      val_in_ff;
   logic                     found_ff;
   logic [SlotBits-1:0]      found_slot_ff;
   logic [SlotBits-1:0]      victim_ff;
   logic                     evict_ff;
   logic [OccBits-1:0]       limit;

   logic                     found_in;
   logic [SlotBits-1:0]      found_slot_in;
   logic                     vic_any;
   logic [SlotBits-1:0]      vic_in;

   logic                            node_ok   [2*MaxEntries];
   logic [CountBits+SlotBits-1:0]   node_key  [2*MaxEntries];
   logic [SlotBits-1:0]             node_slot [2*MaxEntries];

   assign limit = (capacity > CapBits'(MaxEntries)) ? OccBits'(MaxEntries)
                                                      : OccBits'(capacity);

   always_comb begin
      found_in = 1'b0;
      found_slot_in = '0;
      for (int i = MaxEntries - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == key_in_ff) begin
            found_in = 1'b1;
            found_slot_in = SlotBits'(i);
         end
      end
   end

   // pick lowest count, then oldest rank, by a compare tree
   always_comb begin
      for (int i = 0; i < 2*MaxEntries; i++) begin
         node_ok[i] = 1'b0;
         node_key[i] = '0;
         node_slot[i] = '0;
      end
      for (int i = 0; i < MaxEntries; i++) begin
         node_ok[MaxEntries + i] = valid_ff[i];
         node_key[MaxEntries + i] = {count_ff[i], ~rank_ff[i]};
         node_slot[MaxEntries + i] = SlotBits'(i);
      end
      for (int j = MaxEntries - 1; j >= 1; j--) begin
         if (node_ok[2*j] && (!node_ok[2*j+1] || node_key[2*j] <= node_key[2*j+1])) begin
            node_ok[j] = node_ok[2*j];
            node_key[j] = node_key[2*j];
            node_slot[j] = node_slot[2*j];
         end else begin
            node_ok[j] = node_ok[2*j+1];
            node_key[j] = node_key[2*j+1];
            node_slot[j] = node_slot[2*j+1];
         end
      end
      vic_any = node_ok[1];
      vic_in = node_slot[1];
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         mode_ff <= mode;
         key_in_ff <= lookup_key;
         val_in_ff <= write_value;
      end
      if (ctrl.lookup) begin
         found_ff <= found_in;
         found_slot_ff <= found_slot_in;
      end
      if (ctrl.choose) begin
         victim_ff <= vic_in;
         evict_ff <= vic_any && (occ_ff >= limit);
      end
   end

   // commit: apply touch, evict and insert
   logic [MaxEntries-1:0]  valid_mid;
   logic [SlotBits-1:0]    rank_mid [MaxEntries];
   logic                   free_any;
   logic [SlotBits-1:0]    free_slot;
   logic                   do_touch;
   logic                   do_insert;

   assign do_touch  = found_ff && (mode_ff == MODE_GET || limit != '0);
   assign do_insert = mode_ff == MODE_SET && !found_ff && limit != '0;

   always_comb begin
      valid_mid = valid_ff;
      for (int i = 0; i < MaxEntries; i++) rank_mid[i] = rank_ff[i];
      if (do_insert && evict_ff) begin
         valid_mid[victim_ff] = 1'b0;
         for (int i = 0; i < MaxEntries; i++)
            if (valid_ff[i] && rank_ff[i] > rank_ff[victim_ff])
               rank_mid[i] = rank_ff[i] - 1'b1;
      end
      free_any = 1'b0;
      free_slot = '0;
      for (int i = MaxEntries - 1; i >= 0; i--)
         if (!valid_mid[i]) begin
            free_any = 1'b1;
            free_slot = SlotBits'(i);
         end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff <= '0;
      end else if (ctrl.commit) begin
         if (do_touch) begin
            for (int i = 0; i < MaxEntries; i++)
               if (valid_ff[i] && SlotBits'(i) != found_slot_ff &&
                   rank_ff[i] < rank_ff[found_slot_ff])
                  rank_ff[i] <= rank_ff[i] + 1'b1;
            rank_ff[found_slot_ff] <= '0;
            if (count_ff[found_slot_ff] != CountMax)
               count_ff[found_slot_ff] <= count_ff[found_slot_ff] + 1'b1;
            if (mode_ff == MODE_SET) value_ff[found_slot_ff] <= val_in_ff;
         end else if (do_insert) begin
            if (free_any) begin
               for (int i = 0; i < MaxEntries; i++)
                  if (valid_mid[i]) rank_ff[i] <= rank_mid[i] + 1'b1;
               valid_ff <= valid_mid | (MaxEntries'(1) << free_slot);
               key_ff[free_slot] <= key_in_ff;
               value_ff[free_slot] <= val_in_ff;
               count_ff[free_slot] <= CountBits'(1);
               rank_ff[free_slot] <= '0;
               occ_ff <= evict_ff ? occ_ff : occ_ff + 1'b1;
            end else begin
               for (int i = 0; i < MaxEntries; i++) rank_ff[i] <= rank_mid[i];
               valid_ff <= valid_mid;
               if (evict_ff) occ_ff <= occ_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         hit <= found_ff;
         if (mode_ff == MODE_SET) read_value <= '0;
         else if (found_ff) read_value <= value_ff[found_slot_ff];
         else read_value <= '1;
      end
   end

endmodule

// ----- hw/rtl/lfu_control.sv -----
module lfu_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              done,
   output lfu_pkg::ctrl_type ctrl
);
   import lfu_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOKUP = 3'd1;
   localparam logic [2:0] S_CHOOSE = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;

   logic [2:0] state_ff, state_in;
   logic       done_ff;

   always_comb begin
      case (state_ff)
         S_IDLE:   state_in = start ? S_LOOKUP : S_IDLE;
         S_LOOKUP: state_in = S_CHOOSE;
         S_CHOOSE: state_in = S_COMMIT;
         S_COMMIT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   assign ctrl.capture = state_ff == S_IDLE && start;
   assign ctrl.lookup  = state_ff == S_LOOKUP;
   assign ctrl.choose  = state_ff == S_CHOOSE;
   assign ctrl.commit  = state_ff == S_COMMIT;
   assign busy = state_ff != S_IDLE;
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= ctrl.commit;
      end
   end

endmodule

// ----- hw/rtl/lfu_key_value_cache_top.sv -----
// LFU key-value cache, 16 entries, least recently touched breaks count ties.
// Pulse start while busy is low; the item steps through capture, key match,
// victim search and commit, and its result shows on rsp_ ports for one cycle with
// rsp_valid. busy stays high until the commit, so one item is in flight; a new
// item may start the cycle the result appears. Results cannot be stalled.
module lfu_key_value_cache_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic signed [31:0] req_lookup_key,
   input  logic signed [31:0] req_write_value,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic signed [31:0] rsp_read_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [0:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lfu_pkg::*;

   ctrl_type              ctrl;
   logic [CapBits-1:0]    cap_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_CAPACITY) ? 32'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CapBits'(16);
      else if (psel && penable && pwrite && paddr == ADDR_CAPACITY)
         cap_ff <= pwdata[CapBits-1:0];
   end

   lfu_control u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .done(rsp_valid), .ctrl(ctrl)
   );

   lfu_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .capacity(cap_ff),
      .mode(req_mode), .lookup_key(req_lookup_key), .write_value(req_write_value),
      .hit(rsp_hit), .read_value(rsp_read_value)
   );

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");

endmodule
